[sv/kwsd_pkg.sv]
// Shared types, constants and a helper function of the keyword substitution decoder.
package kwsd_pkg;

  localparam int unsigned Letters = 26;
  localparam int unsigned IdxW    = 5;

  localparam logic [7:0] UpperA  = 8'd65;
  localparam logic [7:0] LowerA  = 8'd97;
  localparam logic [7:0] CaseGap = 8'd32;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_KEY    = 2'd1,
    ACT_DECODE = 2'd2
  } kwsd_action_e;

  // Classification of one byte as a letter of either case.
  typedef struct packed {
    logic            is_letter;
    logic [IdxW-1:0] idx;
  } kwsd_letter_t;

  // Update of the key store for one processed transaction.
  typedef struct packed {
    logic            clear;
    logic            add;
    logic [IdxW-1:0] idx;
  } kwsd_upd_t;

  function automatic kwsd_letter_t letter_of(input logic [7:0] c);
    kwsd_letter_t r;
    logic [7:0]   lo;
    r  = '0;
    lo = c - CaseGap;
    if (c >= UpperA && c < UpperA + 8'(Letters)) begin
      r.is_letter = 1'b1;
      r.idx       = IdxW'(c - UpperA);
    end else if (c >= LowerA && c < LowerA + 8'(Letters)) begin
      r.is_letter = 1'b1;
      r.idx       = IdxW'(lo - UpperA);
    end
    return r;
  endfunction

endpackage

[sv/keyword_substitution_decoder_unit.sv]
// Top level of the keyword substitution cipher decoder.
// A keyword substitution cipher decoder that takes one transaction per clock unless
// the output stalls. Each transaction carries an action and a byte: a clear action
// empties the key, a key action adds a letter (folded to upper case) to the cipher
// alphabet if it is new, and a decode action returns one plain character. Key
// letters decode to their order of first appearance in the key; letters absent
// from the key follow in alphabetical order after the key letters. Letters of
// either case come out upper case, other bytes pass through unchanged. Only decode
// actions produce an output transaction; clear, key and the unused action code
// produce none. Every input transaction is registered, then processed by a single
// pass of logic (a key table read and a masked count of unused letters) once the
// output register is free, and the result lands in the output register. The input
// register is freed whenever the output register is empty or is being taken, so
// a stall at the output is seen at the input stall in the same cycle.
module keyword_substitution_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] plain_char_o
);
  import kwsd_pkg::*;

  // Input register stage.
  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_action_q;
  logic [7:0] s1_char_q;

  // Output register stage.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q;

  logic        out_free;
  logic        fire;
  logic        accept;
  kwsd_upd_t   upd_raw, upd_s;
  logic [4:0]  rd_idx;
  logic [4:0]  rd_pos;
  logic [4:0]  distinct_count;
  logic [25:0] letter_used;
  logic        has_result;
  logic [7:0]  plain_char;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  // The held transaction is processed, and the key state updated, on this edge.
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  kwsd_decode u_decode (
    .action_i         (s1_action_q),
    .char_in_i        (s1_char_q),
    .letter_used_i    (letter_used),
    .rd_pos_i         (rd_pos),
    .distinct_count_i (distinct_count),
    .rd_idx_o         (rd_idx),
    .upd_o            (upd_raw),
    .has_result_o     (has_result),
    .plain_char_o     (plain_char)
  );

  // Key state changes only when the transaction actually leaves the input stage.
  always_comb begin
    upd_s       = upd_raw;
    upd_s.clear = upd_raw.clear && fire;
    upd_s.add   = upd_raw.add && fire;
  end

  kwsd_key_store u_key_store (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .upd_i            (upd_s),
    .rd_idx_i         (rd_idx),
    .letter_used_o    (letter_used),
    .rd_pos_o         (rd_pos),
    .distinct_count_o (distinct_count)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (fire && has_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= action_i;
      s1_char_q   <= char_in_i;
    end
    if (fire && has_result) begin
      out_char_q <= plain_char;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign plain_char_o = out_char_q;

endmodule

[sv/kwsd_key_store.sv]
// Key state: used-letter vector, per-letter cipher position and distinct letter count.
module kwsd_key_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kwsd_pkg::kwsd_upd_t    upd_i,
  input  logic [4:0]             rd_idx_i,
  output logic [25:0]            letter_used_o,
  output logic [4:0]             rd_pos_o,
  output logic [4:0]             distinct_count_o
);
  import kwsd_pkg::*;

  logic [Letters-1:0] letter_used_q, letter_used_d;
  logic [IdxW-1:0]    distinct_count_q, distinct_count_d;
  logic [IdxW-1:0]    letter_position_q [Letters];

  always_comb begin
    letter_used_d    = letter_used_q;
    distinct_count_d = distinct_count_q;
    if (upd_i.clear) begin
      letter_used_d    = '0;
      distinct_count_d = '0;
    end else if (upd_i.add) begin
      letter_used_d[upd_i.idx] = 1'b1;
      distinct_count_d         = distinct_count_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_used_q    <= '0;
      distinct_count_q <= '0;
    end else begin
      letter_used_q    <= letter_used_d;
      distinct_count_q <= distinct_count_d;
    end
  end

  // Positions are only read for letters whose used bit is set.
  always_ff @(posedge clk_i) begin
    if (upd_i.add && !upd_i.clear) begin
      letter_position_q[upd_i.idx] <= distinct_count_q;
    end
  end

  assign letter_used_o    = letter_used_q;
  assign distinct_count_o = distinct_count_q;
  assign rd_pos_o         = letter_position_q[rd_idx_i];

endmodule

[sv/kwsd_decode.sv]
// Combinational work for one transaction: key update and message character decode.
module kwsd_decode (
  input  logic [1:0]           action_i,
  input  logic [7:0]           char_in_i,
  input  logic [25:0]          letter_used_i,
  input  logic [4:0]           rd_pos_i,
  input  logic [4:0]           distinct_count_i,
  output logic [4:0]           rd_idx_o,
  output kwsd_pkg::kwsd_upd_t  upd_o,
  output logic                 has_result_o,
  output logic [7:0]           plain_char_o
);
  import kwsd_pkg::*;

  kwsd_letter_t       let_s;
  logic               used_s;
  logic [Letters-1:0] below_mask;
  logic [IdxW-1:0]    unused_cnt;
  logic [IdxW-1:0]    pos_s;

  always_comb begin
    let_s      = letter_of(char_in_i);
    used_s     = letter_used_i[let_s.idx];
    below_mask = (Letters'(1) << let_s.idx) - Letters'(1);
    unused_cnt = IdxW'($countones(~letter_used_i & below_mask));
    pos_s      = used_s ? rd_pos_i : distinct_count_i + unused_cnt;

    upd_o        = '0;
    upd_o.idx    = let_s.idx;
    has_result_o = 1'b0;
    plain_char_o = char_in_i;
    unique case (action_i)
      ACT_CLEAR: upd_o.clear = 1'b1;
      ACT_KEY:   upd_o.add   = let_s.is_letter && !used_s;
      ACT_DECODE: begin
        has_result_o = 1'b1;
        if (let_s.is_letter) begin
          plain_char_o = UpperA + 8'(pos_s);
        end
      end
      default: ;
    endcase
  end

  assign rd_idx_o = let_s.idx;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of the keyword substitution cipher decoder.
`timescale 1ns / 100ps

module tb_top;
  import kwsd_pkg::*;

  // The action code with no enum member: the block must ignore it.
  localparam logic [1:0] ActReserved = 2'd3;

  localparam int unsigned ItemTarget  = 650;
  localparam int unsigned HoldCycles  = 40;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TimeoutNs   = 400000;

  // One expected decode: the byte that went in and the byte that must come out.
  typedef struct packed {
    logic [7:0] cipher;
    logic [7:0] plain;
  } decoded_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [1:0] action_i     = ACT_CLEAR;
  logic [7:0] char_in_i    = 8'h00;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] plain_char_o;

  // Predicted key store of the block.
  logic [Letters-1:0] key_used  = '0;
  logic [IdxW-1:0]    key_pos [Letters];
  logic [IdxW-1:0]    key_count = '0;

  decoded_t    decoded_q [$];
  int unsigned error_count    = 0;
  int unsigned accepted_count = 0;
  int unsigned counted_items  = 0;
  int unsigned checked_count  = 0;

  // Idle control. fast_send is read only by the sending process; fast_recv and
  // rx_hold are written with nonblocking assignments so the sink sees them cleanly.
  logic        fast_send     = 1'b0;
  logic        fast_recv     = 1'b0;
  logic        rx_hold       = 1'b0;
  int unsigned out_wait_left = 0;

  keyword_substitution_decoder_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .char_in_i    (char_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .plain_char_o (plain_char_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Applies one accepted transaction to the predicted key store. A decode
  // transaction queues the plain character that the block must return.
  function automatic void apply_to_key(input logic [1:0] act, input logic [7:0] ch);
    logic            is_let;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] pos;
    decoded_t        exp_item;
    is_let = 1'b0;
    idx    = '0;
    if (ch >= UpperA && ch < UpperA + 8'(Letters)) begin
      is_let = 1'b1;
      idx    = IdxW'(ch - UpperA);
    end else if (ch >= LowerA && ch < LowerA + 8'(Letters)) begin
      is_let = 1'b1;
      idx    = IdxW'(ch - LowerA);
    end
    case (act)
      ACT_CLEAR: begin
        // Stale positions stay behind; only the used mask and the count go.
        key_used  = '0;
        key_count = '0;
      end
      ACT_KEY: begin
        if (is_let && !key_used[idx]) begin
          key_used[idx] = 1'b1;
          key_pos[idx]  = key_count;
          key_count     = key_count + 1'b1;
        end
      end
      ACT_DECODE: begin
        exp_item.cipher = ch;
        exp_item.plain  = ch;
        if (is_let) begin
          if (key_used[idx]) begin
            pos = key_pos[idx];
          end else begin
            // Letters outside the key follow the key letters in alphabetical order.
            pos = key_count;
            for (int i = 0; i < int'(idx); i++) begin
              if (!key_used[i]) pos = pos + 1'b1;
            end
          end
          exp_item.plain = UpperA + 8'(pos);
        end
        decoded_q.push_back(exp_item);
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one transaction after a random gap and waits for it to be taken.
  // Called right after a rising edge; valid is only lowered when a gap follows.
  task automatic send_item(input logic [1:0] act, input logic [7:0] ch);
    int unsigned gap;
    gap = fast_send ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    char_in_i  <= ch;
    do @(posedge clk_i); while (in_stall_o);
    accepted_count++;
    // Reserved actions and non-letter key bytes leave no trace, so they are
    // not counted toward the amount of stimulus.
    if (act != ActReserved &&
        !(act == ACT_KEY && !((ch >= UpperA && ch < UpperA + 8'(Letters)) ||
                              (ch >= LowerA && ch < LowerA + 8'(Letters)))))
      counted_items++;
    apply_to_key(act, ch);
  endtask

  function automatic logic [7:0] random_letter();
    return ($urandom_range(0, 1) ? LowerA : UpperA) + 8'($urandom_range(0, 25));
  endfunction

  // Result sink: checks every accepted result against the oldest prediction and
  // draws a fresh stall length after each one.
  always @(posedge clk_i) begin : result_sink
    decoded_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_count++;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with no decode pending", plain_char_o));
      end else begin
        want = decoded_q.pop_front();
        if (plain_char_o !== want.plain)
          report_mismatch($sformatf("cipher 0x%02h: plain_char 0x%02h, predicted 0x%02h",
                                    want.cipher, plain_char_o, want.plain));
      end
      out_wait_left = fast_recv ? 0 : $urandom_range(0, 4);
    end
    out_stall_i <= rx_hold || (out_wait_left != 0);
    if (out_wait_left != 0) out_wait_left--;
  end

  // Boundary bytes around both letter ranges, an empty key, mixed case and
  // repeated key letters, a reserved action, and a decode after a clear.
  task automatic test_directed();
    send_item(ACT_DECODE, "A");
    send_item(ACT_DECODE, "z");
    send_item(ACT_DECODE, 8'h00);
    send_item(ACT_DECODE, 8'hFF);
    send_item(ACT_KEY, "Z");
    send_item(ACT_KEY, "e");
    send_item(ACT_KEY, "b");
    send_item(ACT_KEY, "R");
    send_item(ACT_KEY, "a");
    send_item(ACT_KEY, "E");
    send_item(ACT_KEY, "1");
    send_item(ACT_KEY, 8'hC1);
    send_item(ActReserved, "Q");
    send_item(ACT_DECODE, "a");
    send_item(ACT_DECODE, "Z");
    send_item(ACT_DECODE, "c");
    send_item(ACT_DECODE, "y");
    send_item(ACT_DECODE, "@");
    send_item(ACT_DECODE, "{");
    send_item(ACT_CLEAR, "x");
    send_item(ACT_DECODE, "Z");
  endtask

  // A key that holds every letter once, in shuffled order and random case,
  // so the distinct count reaches its top value.
  task automatic test_full_alphabet_key();
    int unsigned order [Letters];
    int unsigned j;
    int unsigned tmp;
    for (int i = 0; i < Letters; i++) order[i] = i;
    for (int i = Letters - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_item(ACT_CLEAR, 8'h00);
    for (int i = 0; i < Letters; i++)
      send_item(ACT_KEY, ($urandom_range(0, 1) ? LowerA : UpperA) + 8'(order[i]));
    send_item(ACT_KEY, random_letter());
    repeat (10) send_item(ACT_DECODE, random_letter());
  endtask

  // The sink holds off for a long stretch while the sender keeps offering
  // decodes back to back, so the pipeline fills and stalls its input.
  task automatic test_output_hold_off();
    send_item(ACT_CLEAR, 8'h00);
    send_item(ACT_KEY, "Q");
    send_item(ACT_KEY, "u");
    send_item(ACT_KEY, "i");
    send_item(ACT_KEY, "z");
    fast_send = 1'b1;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        repeat (20) send_item(ACT_DECODE, random_letter());
      end
    join
    fast_send = 1'b0;
  endtask

  // Mostly well-formed sessions (clear, key, message) with random content,
  // some keys left in place to be extended, and some bursts of raw noise.
  task automatic test_random_traffic();
    int unsigned key_len;
    int unsigned msg_len;
    while (counted_items < ItemTarget) begin
      fast_send = ($urandom_range(0, 5) == 0);
      fast_recv <= fast_send;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 7) != 0) send_item(ACT_CLEAR, 8'($urandom_range(0, 255)));
        key_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        repeat (key_len)
          send_item(ACT_KEY, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                         : random_letter());
        msg_len = $urandom_range(1, 16);
        repeat (msg_len)
          send_item(ACT_DECODE, ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                            : random_letter());
      end
    end
    fast_send = 1'b0;
    fast_recv <= 1'b0;
  endtask

  initial begin : main_sequence
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_alphabet_key();
    test_output_hold_off();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    // Clear and key transactions give no result, so let the pipeline empty.
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d transactions (%0d effective), checked %0d decoded characters.",
             accepted_count, counted_items, checked_count);
    $display("Covered empty and full keys, mixed case, non-letters, reserved action, hold-off.");
    if (error_count == 0) begin
      $display("keyword_substitution_decoder_unit regression: pass");
    end else begin
      $display("keyword_substitution_decoder_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Timeout with %0d decodes still pending.", decoded_q.size());
    $display("keyword_substitution_decoder_unit regression: fail");
    $finish;
  end

endmodule

[filelist.f]
sv/kwsd_pkg.sv
sv/kwsd_key_store.sv
sv/kwsd_decode.sv
sv/keyword_substitution_decoder_unit.sv
tb/sv/tb_top.sv
